@@ design/nmrb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmrb_pkg
// shared types and constants of the named mailbox ring bank
// ----------------------------------------------------------------------------
package nmrb_pkg;

  localparam int unsigned BoxCountDef    = 16;
  localparam int unsigned BoxCapacityDef = 64;
  localparam int unsigned NameBytesDef   = 7;
  localparam int unsigned MsgMax         = 8;
  localparam int unsigned NameW          = 56;
  localparam int unsigned HandleMax      = 255;

  typedef enum logic [1:0] {
    OP_OPEN  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_SEND  = 2'd2,
    OP_RECV  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BLOCK = 2'd1,
    ST_NOBOX = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  opened_index;
    logic [31:0] recv_low;
    logic [31:0] recv_high;
  } result_t;

endpackage

@@ design/named_mailbox_ring_bank_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// named_mailbox_ring_bank_top
// bank of named byte mailboxes, each a ring buffer kept in shared memories
// ----------------------------------------------------------------------------
// channel  dir  beat fields (low bit first)
// s_axis   in   op, mailbox, box_name, byte_count, send_low, send_high
// m_axis   out  status, opened_index, recv_low, recv_high
//
// one beat at a time. open scans the mailbox table (one table read per box);
// send and receive move their bytes with one byte memory access per cycle;
// close, refused and zero-length send and receive skip the byte phase.
// the next beat is accepted the cycle after the result is loaded.
// reset empties every mailbox at once through per-box count valid flags; no
// clearing pass, names and bytes stay undefined until written. the result
// register lets a new beat be accepted while the previous result waits on
// m_axis_tready; a second finished beat waits in its last state.
// ----------------------------------------------------------------------------
module named_mailbox_ring_bank_top
  import nmrb_pkg::*;
#(
  parameter int unsigned BOX_COUNT    = BoxCountDef,
  parameter int unsigned BOX_CAPACITY = BoxCapacityDef,
  parameter int unsigned NAME_BYTES   = NameBytesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // op[1:0], mailbox[5:2], box_name[61:6], byte_count[65:62],
  // send_low[97:66], send_high[129:98], zero fill to 136
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[1:0], opened_index[5:2], recv_low[37:6], recv_high[69:38], zero fill
  output logic [71:0]  m_axis_tdata
);

  localparam int unsigned BoxW  = (BOX_COUNT > 1) ? $clog2(BOX_COUNT) : 1;
  localparam int unsigned SlotW = $clog2(BOX_CAPACITY);
  localparam int unsigned CntW  = $clog2(2 * BOX_CAPACITY);
  localparam int unsigned AddrW = $clog2(BOX_COUNT * BOX_CAPACITY);
  localparam int unsigned ScanW = $clog2(BOX_COUNT + 1);

  localparam logic [CntW-1:0] CntTop  = CntW'(2 * BOX_CAPACITY - 1);
  localparam logic [CntW-1:0] CntCap  = CntW'(BOX_CAPACITY);
  localparam logic [CntW-1:0] CntWrap = CntW'(2 * BOX_CAPACITY);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_BYTES = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  // mailbox table memories (one synchronous read port each)
  logic [NameW-1:0] name_mem [BOX_COUNT];
  logic [CntW-1:0]  wcnt_mem [BOX_COUNT];
  logic [CntW-1:0]  rcnt_mem [BOX_COUNT];
  logic [7:0]       byte_mem [BOX_COUNT*BOX_CAPACITY];
  // handle counts live in flops: a zero count doubles as the free mark
  logic [7:0]       hcnt_q [BOX_COUNT];
  // counts of a box read as zero until first written after reset
  logic [BOX_COUNT-1:0] cnt_vld_q;

  state_e state_q, state_d;
  logic [1:0]       op_q;
  logic [3:0]       box_in_q;
  logic [NameW-1:0] name_q;
  logic [3:0]       cnt_q;
  logic [63:0]      msg_q;
  logic [63:0]      got_q;
  logic [3:0]       idx_q;
  logic [ScanW-1:0] scan_q;
  logic [ScanW-1:0] rd_box_q;
  logic [BoxW-1:0]  box_q;
  logic [CntW-1:0]  wcnt_q, rcnt_q;
  logic             free_seen_q;
  logic [BoxW-1:0]  free_box_q;
  logic             byte_rd_q;
  logic             found_q;

  logic [NameW-1:0] name_rd_q;
  logic [CntW-1:0]  wcnt_rd_q, rcnt_rd_q;
  logic [7:0]       byte_rd_data_q;

  result_t res_q, res_d;
  logic    res_valid_q;
  logic    res_load;

  // input unpack
  logic [1:0]       in_op;
  logic [3:0]       in_box;
  logic [NameW-1:0] in_name, in_name_norm;
  logic [3:0]       in_cnt;
  assign in_op   = s_axis_tdata[1:0];
  assign in_box  = s_axis_tdata[5:2];
  assign in_name = s_axis_tdata[61:6];
  assign in_cnt  = s_axis_tdata[65:62];

  // name ends at first zero byte, and only NAME_BYTES bytes count
  always_comb begin
    logic live;
    live = 1'b1;
    in_name_norm = '0;
    for (int b = 0; b < 7; b++) begin
      if (b >= NAME_BYTES || in_name[8*b +: 8] == 8'd0) live = 1'b0;
      if (live) in_name_norm[8*b +: 8] = in_name[8*b +: 8];
    end
  end

  logic accept;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  logic in_range;
  assign in_range = ({3'b000, box_in_q} < 7'(BOX_COUNT));

  // result register loads when empty or emptied in the same cycle
  assign res_load = (state_q == S_DONE) && (!res_valid_q || m_axis_tready);

  // memory addressing
  logic [BoxW-1:0]  tbl_rd_addr;
  logic [AddrW-1:0] byte_addr;
  logic [CntW-1:0]  wcnt_cur, rcnt_cur;
  logic [CntW-1:0]  fill;
  logic [CntW:0]    fill_sum;
  logic [CntW-1:0]  cur_cnt;
  logic [SlotW-1:0] slot;
  assign tbl_rd_addr = (state_q == S_SCAN) ? rd_box_q[BoxW-1:0] : box_q;
  assign wcnt_cur    = cnt_vld_q[box_q] ? wcnt_rd_q : '0;
  assign rcnt_cur    = cnt_vld_q[box_q] ? rcnt_rd_q : '0;
  assign fill        = (wcnt_cur >= rcnt_cur) ? (wcnt_cur - rcnt_cur)
                                              : (wcnt_cur - rcnt_cur + CntWrap);
  assign fill_sum    = {1'b0, fill} + (CntW+1)'(cnt_q);
  assign cur_cnt     = (op_q == OP_SEND) ? wcnt_q : rcnt_q;
  assign slot        = (cur_cnt >= CntCap) ? SlotW'(cur_cnt - CntCap) : SlotW'(cur_cnt);
  assign byte_addr   = AddrW'(box_q * BOX_CAPACITY) + AddrW'(slot);

  logic byte_we, byte_re, cnt_we, name_we, clr_we;
  logic [BoxW-1:0] name_waddr;
  logic [BoxW-1:0] scan_box;
  assign scan_box = scan_q[BoxW-1:0];

  // scan hit on the entry read in the previous cycle
  logic scan_hit;
  assign scan_hit = (state_q == S_SCAN) && (scan_q != '0) &&
                    (hcnt_q[BoxW'(scan_q - 1'b1)] != 8'd0) && (name_rd_q == name_q);

  always_ff @(posedge clk_i) begin
    name_rd_q <= name_mem[tbl_rd_addr];
    wcnt_rd_q <= wcnt_mem[tbl_rd_addr];
    rcnt_rd_q <= rcnt_mem[tbl_rd_addr];
    if (name_we) name_mem[name_waddr] <= name_q;
    if (clr_we) begin
      wcnt_mem[box_q] <= '0;
      rcnt_mem[box_q] <= '0;
    end else if (cnt_we) begin
      wcnt_mem[box_q] <= wcnt_q;
      rcnt_mem[box_q] <= rcnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_we) byte_mem[byte_addr] <= msg_q[7:0];
    if (byte_re) byte_rd_data_q <= byte_mem[byte_addr];
  end

  always_comb begin
    state_d = state_q;
    byte_we = 1'b0;
    byte_re = 1'b0;
    cnt_we  = 1'b0;
    name_we = 1'b0;
    clr_we  = 1'b0;
    name_waddr = free_box_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_READ;
      S_READ:  state_d = (op_q == OP_OPEN) ? S_SCAN : S_EXEC;
      S_EXEC:  begin
        if (op_q == OP_CLOSE) begin
          clr_we  = in_range;
          state_d = S_DONE;
        end else if (!in_range || cnt_q == 4'd0) begin
          state_d = S_DONE;
        end else if (op_q == OP_SEND && fill_sum > (CntW+1)'(BOX_CAPACITY)) begin
          state_d = S_DONE;
        end else if (op_q == OP_RECV && fill < CntW'(cnt_q)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_BYTES;
        end
      end
      S_SCAN:  begin
        if (scan_q == ScanW'(BOX_COUNT)) begin
          // claim a free box only when no open box matched
          name_we = free_seen_q && !found_q && !scan_hit;
          state_d = S_DONE;
        end
      end
      S_BYTES: begin
        byte_we = (op_q == OP_SEND) && (idx_q != cnt_q);
        byte_re = (op_q == OP_RECV) && (idx_q != cnt_q);
        if (idx_q == cnt_q && !byte_rd_q) begin
          cnt_we  = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE:  if (res_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      cnt_vld_q   <= '0;
      for (int k = 0; k < BOX_COUNT; k++) hcnt_q[k] <= 8'd0;
    end else begin
      state_q <= state_d;
      if (res_load) res_valid_q <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) res_valid_q <= 1'b0;
      if (clr_we || cnt_we) cnt_vld_q[box_q] <= 1'b1;
      if (state_q == S_EXEC && op_q == OP_CLOSE && in_range)
        hcnt_q[box_q] <= 8'd0;
      if (scan_hit && !found_q && hcnt_q[BoxW'(scan_q - 1'b1)] < 8'(HandleMax))
        hcnt_q[BoxW'(scan_q - 1'b1)] <= hcnt_q[BoxW'(scan_q - 1'b1)] + 8'd1;
      if (name_we) hcnt_q[free_box_q] <= 8'd1;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= in_op;
      box_in_q <= in_box;
      box_q    <= BoxW'(in_box);
      name_q   <= in_name_norm;
      cnt_q    <= (in_cnt > 4'(MsgMax)) ? 4'(MsgMax) : in_cnt;
      msg_q    <= s_axis_tdata[129:66];
      got_q    <= '0;
      idx_q    <= '0;
      scan_q   <= '0;
      rd_box_q <= '0;
      free_seen_q <= 1'b0;
      found_q  <= 1'b0;
      byte_rd_q <= 1'b0;
    end
    if (state_q == S_EXEC) begin
      wcnt_q <= wcnt_cur;
      rcnt_q <= rcnt_cur;
    end
    if (state_q == S_SCAN) begin
      if (rd_box_q != ScanW'(BOX_COUNT)) rd_box_q <= rd_box_q + 1'b1;
    end
    if (state_q == S_SCAN && scan_q != ScanW'(BOX_COUNT)) scan_q <= scan_q + 1'b1;
    if (state_q == S_SCAN && !free_seen_q && hcnt_q[scan_box] == 8'd0
        && scan_q != ScanW'(BOX_COUNT)) begin
      free_seen_q <= 1'b1;
      free_box_q  <= scan_box;
    end
    if (scan_hit && !found_q) begin
      found_q <= 1'b1;
      idx_q   <= 4'(scan_q - 1'b1);
    end
    if (state_q == S_BYTES) begin
      byte_rd_q <= byte_re;
      if (byte_rd_q) got_q <= {byte_rd_data_q, got_q[63:8]};
      if (idx_q != cnt_q) begin
        idx_q <= idx_q + 4'd1;
        msg_q <= {8'd0, msg_q[63:8]};
        if (op_q == OP_SEND)
          wcnt_q <= (wcnt_q == CntTop) ? '0 : wcnt_q + 1'b1;
        else
          rcnt_q <= (rcnt_q == CntTop) ? '0 : rcnt_q + 1'b1;
      end
    end
  end

  // recv bytes arrive lowest first into the top; align by count
  logic [63:0] got_aligned;
  always_comb begin
    got_aligned = '0;
    for (int b = 1; b <= 8; b++)
      if (4'(b) == cnt_q) got_aligned = got_q >> (64 - 8*b);
  end

  always_comb begin
    res_d = '0;
    unique case (op_q)
      OP_OPEN: begin
        if (found_q) res_d.opened_index = idx_q;
        else if (free_seen_q) res_d.opened_index = 4'(free_box_q);
        else res_d.status = ST_NOBOX;
      end
      OP_CLOSE: res_d.status = ST_OK;
      default: begin
        if (!in_range || idx_q != cnt_q) res_d.status = ST_BLOCK;
        else if (op_q == OP_RECV && cnt_q != 4'd0) begin
          res_d.recv_low  = got_aligned[31:0];
          res_d.recv_high = got_aligned[63:32];
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (res_load) res_q <= res_d;
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {2'b00, res_q.recv_high, res_q.recv_low,
                          res_q.opened_index, res_q.status};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("pending result dropped or changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> m_axis_tvalid) else $error("result not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_we |-> !byte_re) else $error("byte memory double access");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BYTES) |-> (idx_q <= cnt_q)) else $error("byte index overrun");

endmodule
